// ===== rtl/core/page_cache_fifo_lru_tracker_macros.svh =====
// Assertion helpers shared by the tracker RTL.
`ifndef PAGE_CACHE_FIFO_LRU_TRACKER_MACROS_SVH
`define PAGE_CACHE_FIFO_LRU_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCFLT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCFLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pcflt_pkg.sv =====
`timescale 1ns / 1ps

package pcflt_pkg;

    localparam int PAGE_W     = 12;
    localparam int PAGE_EXT_W = 17;  // holds any page bound up to 65536
    localparam int LIMIT_W    = 7;
    localparam int PCOUNT_W   = 13;
    localparam int OCC_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESIDENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LRU_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_MODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = 2'd3;

    localparam logic [LIMIT_W-1:0]  RST_MAX_RESIDENT = 7'd30;
    localparam logic [PCOUNT_W-1:0] RST_PAGE_COUNT   = 13'd4096;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_FIND,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic present;
        logic high_res;
    } t_map_entry;

endpackage

// ===== rtl/core/pcflt_age_list.sv =====
`timescale 1ns / 1ps

module pcflt_age_list #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [pcflt_pkg::PAGE_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [pcflt_pkg::PAGE_W-1:0] i_wr_data
);
    import pcflt_pkg::*;

    logic [PAGE_W-1:0] r_mem [DEPTH];
    logic [PAGE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/pcflt_page_map.sv =====
`timescale 1ns / 1ps

module pcflt_page_map #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    output logic                    o_busy,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr,
    output pcflt_pkg::t_map_entry   o_rd_data,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  pcflt_pkg::t_map_entry   i_wr_data
);
    import pcflt_pkg::*;

    t_map_entry r_mem [DEPTH];
    t_map_entry r_rd_data;
    logic       r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_map_entry    wr_data;

    // Clearing pass owns the write port after reset.
    always_comb begin
        wr_en   = r_clr_busy | i_wr_en;
        wr_addr = r_clr_busy ? r_clr_addr : i_wr_addr;
        wr_data = r_clr_busy ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_busy    = r_clr_busy;
    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/page_cache_fifo_lru_tracker.sv =====
// Path with the output free: a rejected page goes from ST_IDLE straight to ST_DONE;
// a miss, an insert without eviction or a FIFO-mode hit passes through ST_MAP to ST_DONE.
// An evicting insert or an LRU touch walks the age list once.
// One item in flight: the next item can be accepted once the result is registered on the outputs.
// Reset is synchronous, active low; afterwards a clearing pass sweeps every entry of
// the page map and input stays stalled until it ends.
`timescale 1ns / 1ps
`include "page_cache_fifo_lru_tracker_macros.svh"

module page_cache_fifo_lru_tracker #(
    parameter int MAX_PAGES   = 4096,
    parameter int MAX_ENTRIES = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcflt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pcflt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [pcflt_pkg::PAGE_W-1:0]      i_page,
    input  logic                              i_high_res,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_hit,
    output logic                              o_rejected,
    output logic                              o_evict_valid,
    output logic [pcflt_pkg::PAGE_W-1:0]      o_evicted_page,
    output logic [pcflt_pkg::OCC_W-1:0]       o_occupancy
);
    import pcflt_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int PW = $clog2(MAX_PAGES);
    localparam int XW = (CW > LIMIT_W) ? CW : LIMIT_W;

    // configuration
    logic [LIMIT_W-1:0]  r_max_resident;
    logic                r_lru_mode;
    logic                r_prog_mode;
    logic [PCOUNT_W-1:0] r_page_count;

    // sequencer
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_tag, n_tag;
    logic            r_dv, n_dv;
    logic            r_op, n_op;
    logic            r_hr, n_hr;
    logic [PAGE_W-1:0] r_page, n_page;
    logic            r_hit, n_hit;
    logic            r_rej, n_rej;
    logic            r_evict, n_evict;
    logic [PAGE_W-1:0] r_victim, n_victim;

    // output register
    logic              r_out_valid, n_out_valid;
    logic              r_o_hit, n_o_hit;
    logic              r_o_rej, n_o_rej;
    logic              r_o_evict, n_o_evict;
    logic [PAGE_W-1:0] r_o_evp, n_o_evp;
    logic [OCC_W-1:0]  r_o_occ, n_o_occ;

    // memory ports
    logic          map_busy;
    logic          map_rd_en;
    t_map_entry    map_rd;
    logic          map_we;
    logic [PW-1:0] map_wa;
    t_map_entry    map_wd;
    logic          age_rd_en;
    logic [PAGE_W-1:0] age_rd;
    logic          age_we;
    logic [CW-1:0] age_wr_idx;
    logic [PAGE_W-1:0] age_wd;

    logic                  accept;
    logic                  reject;
    logic                  out_free;
    logic                  match;
    logic                  issue;
    logic [XW-1:0]         cl_x;
    logic [CW-1:0]         lim;
    logic [PAGE_EXT_W-1:0] in_page_x;
    logic [PAGE_EXT_W-1:0] cur_page_x;
    logic [PAGE_EXT_W-1:0] vic_page_x;

    pcflt_page_map #(
        .DEPTH (MAX_PAGES),
        .AW    (PW)
    ) u_page_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_busy    (map_busy),
        .i_rd_en   (map_rd_en),
        .i_rd_addr (in_page_x[PW-1:0]),
        .o_rd_data (map_rd),
        .i_wr_en   (map_we),
        .i_wr_addr (map_wa),
        .i_wr_data (map_wd)
    );

    pcflt_age_list #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_age_list (
        .i_clk     (i_clk),
        .i_rd_en   (age_rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (age_rd),
        .i_wr_en   (age_we),
        .i_wr_addr (age_wr_idx[AW-1:0]),
        .i_wr_data (age_wd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_resident <= RST_MAX_RESIDENT;
            r_lru_mode     <= 1'b0;
            r_prog_mode    <= 1'b0;
            r_page_count   <= RST_PAGE_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_RESIDENT: r_max_resident <= i_cfg_data[LIMIT_W-1:0];
                CFG_LRU_MODE:     r_lru_mode     <= i_cfg_data[0];
                CFG_PROG_MODE:    r_prog_mode    <= i_cfg_data[0];
                CFG_PAGE_COUNT:   r_page_count   <= i_cfg_data[PCOUNT_W-1:0];
            endcase
        end
    end

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE) || map_busy;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign in_page_x  = PAGE_EXT_W'(i_page);
    assign cur_page_x = PAGE_EXT_W'(r_page);
    assign vic_page_x = PAGE_EXT_W'(r_victim);
    assign reject     = ({1'b0, i_page} >= r_page_count) ||
                        (in_page_x >= PAGE_EXT_W'(MAX_PAGES));

    // limit clamped to 1 .. MAX_ENTRIES-1
    assign cl_x = XW'(r_max_resident);
    assign lim  = (cl_x == '0) ? CW'(1) :
                  (cl_x > XW'(MAX_ENTRIES - 1)) ? CW'(MAX_ENTRIES - 1) : CW'(cl_x);

    assign match = r_dv && (age_rd == r_page);
    assign issue = (r_idx < r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_tag       = r_tag;
        n_dv        = r_dv;
        n_op        = r_op;
        n_hr        = r_hr;
        n_page      = r_page;
        n_hit       = r_hit;
        n_rej       = r_rej;
        n_evict     = r_evict;
        n_victim    = r_victim;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_hit     = r_o_hit;
        n_o_rej     = r_o_rej;
        n_o_evict   = r_o_evict;
        n_o_evp     = r_o_evp;
        n_o_occ     = r_o_occ;
        map_rd_en   = 1'b0;
        map_we      = 1'b0;
        map_wa      = cur_page_x[PW-1:0];
        map_wd      = '0;
        age_rd_en   = 1'b0;
        age_we      = 1'b0;
        age_wr_idx  = r_count;
        age_wd      = r_page;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op      = i_operation;
                    n_hr      = i_high_res;
                    n_page    = i_page;
                    n_hit     = 1'b0;
                    n_rej     = reject;
                    n_evict   = 1'b0;
                    n_victim  = '0;
                    map_rd_en = 1'b1;
                    n_state   = reject ? ST_DONE : ST_MAP;
                end
            end

            ST_MAP: begin
                n_idx   = '0;
                n_dv    = 1'b0;
                n_state = ST_DONE;
                if (r_op == OP_LOOKUP) begin
                    if (map_rd.present && (!r_prog_mode || map_rd.high_res)) begin
                        n_hit = 1'b1;
                        if (r_lru_mode) begin
                            n_state = ST_FIND;
                        end
                    end
                end else if (map_rd.present) begin
                    n_hit = 1'b1;
                    if (r_hr) begin
                        map_we = 1'b1;
                        map_wd = '{present: 1'b1, high_res: 1'b1};
                    end
                    if (r_lru_mode) begin
                        n_state = ST_FIND;
                    end
                end else if (r_count < CW'(MAX_ENTRIES)) begin
                    // new page goes in as newest
                    map_we  = 1'b1;
                    map_wd  = '{present: 1'b1, high_res: r_hr};
                    age_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    if (r_count >= lim) begin
                        n_evict = 1'b1;
                        n_state = ST_SHIFT;
                    end
                end
            end

            ST_FIND: begin
                if (match) begin
                    n_idx   = r_tag + CW'(1);
                    n_dv    = 1'b0;
                    n_state = ST_SHIFT;
                end else if (issue) begin
                    age_rd_en = 1'b1;
                    n_dv      = 1'b1;
                    n_tag     = r_idx;
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        n_state = ST_DONE;
                    end
                end
            end

            ST_SHIFT: begin
                // read k, write k-1 in the next cycle; slot 0 read only on eviction
                n_dv = issue;
                if (issue) begin
                    age_rd_en = 1'b1;
                    n_tag     = r_idx;
                    n_idx     = r_idx + CW'(1);
                end
                if (r_dv) begin
                    if (r_tag == '0) begin
                        n_victim = age_rd;
                    end else begin
                        age_we     = 1'b1;
                        age_wr_idx = r_tag - CW'(1);
                        age_wd     = age_rd;
                    end
                end
                if (!issue && !r_dv) begin
                    if (r_evict) begin
                        n_count = r_count - CW'(1);
                        map_we  = 1'b1;
                        map_wa  = vic_page_x[PW-1:0];
                        map_wd  = '0;
                    end else begin
                        age_we     = 1'b1;
                        age_wr_idx = r_count - CW'(1);
                        age_wd     = r_page;
                    end
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_hit     = r_hit;
                    n_o_rej     = r_rej;
                    n_o_evict   = r_evict;
                    n_o_evp     = r_victim;
                    n_o_occ     = OCC_W'(r_count);
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag     <= n_tag;
        r_op      <= n_op;
        r_hr      <= n_hr;
        r_page    <= n_page;
        r_hit     <= n_hit;
        r_rej     <= n_rej;
        r_evict   <= n_evict;
        r_victim  <= n_victim;
        r_o_hit   <= n_o_hit;
        r_o_rej   <= n_o_rej;
        r_o_evict <= n_o_evict;
        r_o_evp   <= n_o_evp;
        r_o_occ   <= n_o_occ;
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_o_hit;
    assign o_rejected     = r_o_rej;
    assign o_evict_valid  = r_o_evict;
    assign o_evicted_page = r_o_evp;
    assign o_occupancy    = r_o_occ;

    `PCFLT_ASSERT_IMPLY(a_idle_count_bound, i_clk, i_rst_n,
        r_state == ST_IDLE, r_count <= CW'(MAX_ENTRIES - 1),
        "occupancy above capacity between items")
    `PCFLT_ASSERT_NEXT(a_accept_next_state, i_clk, i_rst_n,
        accept, r_state == ST_MAP || r_state == ST_DONE,
        "accepted item did not start map lookup")
    `PCFLT_ASSERT_IMPLY(a_shift_write_range, i_clk, i_rst_n,
        r_state == ST_SHIFT && age_we, age_wr_idx < r_count,
        "age list write beyond occupancy")
    `PCFLT_ASSERT_IMPLY(a_reject_alone, i_clk, i_rst_n,
        r_out_valid && r_o_rej, !r_o_hit && !r_o_evict,
        "rejected item reports hit or eviction")
    `PCFLT_ASSERT_IMPLY(a_evict_on_miss, i_clk, i_rst_n,
        r_out_valid && r_o_evict, !r_o_hit && !r_o_rej,
        "eviction reported on a hit")

endmodule
